// ----- hw/rtl/yuyv_to_rgb_pixel_converter_top_assert.svh -----
// Assertion macros for the converter top level.
`ifndef YUYV_TO_RGB_PIXEL_CONVERTER_TOP_ASSERT_SVH
`define YUYV_TO_RGB_PIXEL_CONVERTER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define YRGB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define YRGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/yrgb_pkg.sv -----
`timescale 1ns / 1ps
package yrgb_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ProdW  = 17;
  localparam int unsigned TermW  = 9;
  localparam int unsigned PackW  = 16;

  localparam logic signed [ProdW-1:0] CoefRedV   = 17'sd359;
  localparam logic signed [ProdW-1:0] CoefGreenU = 17'sd88;
  localparam logic signed [ProdW-1:0] CoefGreenV = 17'sd183;
  localparam logic signed [ProdW-1:0] CoefBlueU  = 17'sd454;

  // Chroma contributions after the floor shift by 256.
  typedef struct packed {
    logic signed [TermW-1:0] red;
    logic signed [TermW-1:0] green;
    logic signed [TermW-1:0] blue;
  } yrgb_terms_t;

  // Contents of the register between the chroma stage and the lanes.
  typedef struct packed {
    logic              valid;
    logic              frame_last;
    logic [ByteW-1:0]  luma_first;
    logic [ByteW-1:0]  luma_second;
    yrgb_terms_t       terms;
  } yrgb_stage_t;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [PackW-1:0] rgb565;
  } yrgb_pixel_t;

endpackage

// ----- hw/rtl/yrgb_chroma.sv -----
`timescale 1ns / 1ps
module yrgb_chroma (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [yrgb_pkg::ByteW-1:0]  luma_first,
  input  logic [yrgb_pkg::ByteW-1:0]  chroma_blue,
  input  logic [yrgb_pkg::ByteW-1:0]  luma_second,
  input  logic [yrgb_pkg::ByteW-1:0]  chroma_red,
  input  logic                        frame_last,
  output yrgb_pkg::yrgb_stage_t       stage
);
  import yrgb_pkg::*;

  logic signed [ByteW-1:0] du;
  logic signed [ByteW-1:0] dv;
  logic signed [ProdW-1:0] du_ext;
  logic signed [ProdW-1:0] dv_ext;
  logic signed [ProdW-1:0] red_prod;
  logic signed [ProdW-1:0] green_prod;
  logic signed [ProdW-1:0] blue_prod;
  yrgb_stage_t             stage_r;
  yrgb_stage_t             stage_nxt;

  // Flipping the top bit subtracts the 128 offset into two's complement.
  assign du = $signed({~chroma_blue[ByteW-1], chroma_blue[ByteW-2:0]});
  assign dv = $signed({~chroma_red[ByteW-1], chroma_red[ByteW-2:0]});
  assign du_ext = {{(ProdW-ByteW){du[ByteW-1]}}, du};
  assign dv_ext = {{(ProdW-ByteW){dv[ByteW-1]}}, dv};

  assign red_prod   = CoefRedV * dv_ext;
  assign green_prod = CoefGreenU * du_ext + CoefGreenV * dv_ext;
  assign blue_prod  = CoefBlueU * du_ext;

  always_comb begin
    stage_nxt             = stage_r;
    stage_nxt.valid       = accept;
    stage_nxt.frame_last  = frame_last;
    stage_nxt.luma_first  = luma_first;
    stage_nxt.luma_second = luma_second;
    // Taking the upper bits is an arithmetic shift, so negative terms floor.
    stage_nxt.terms.red   = red_prod[ProdW-1:ProdW-TermW];
    stage_nxt.terms.green = green_prod[ProdW-1:ProdW-TermW];
    stage_nxt.terms.blue  = blue_prod[ProdW-1:ProdW-TermW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage = stage_r;

endmodule

// ----- hw/rtl/yrgb_lane.sv -----
`timescale 1ns / 1ps
module yrgb_lane (
  input  logic [yrgb_pkg::ByteW-1:0] luma,
  input  yrgb_pkg::yrgb_terms_t      terms,
  output yrgb_pkg::yrgb_pixel_t      pixel
);
  import yrgb_pkg::*;

  localparam int unsigned SumW = TermW + 2;

  logic signed [SumW-1:0] luma_ext;
  logic signed [SumW-1:0] red_sum;
  logic signed [SumW-1:0] green_sum;
  logic signed [SumW-1:0] blue_sum;

  function automatic logic [ByteW-1:0] sat8(input logic signed [SumW-1:0] x);
    logic [ByteW-1:0] res;
    if (x[SumW-1]) begin
      res = '0;
    end else if (|x[SumW-2:ByteW]) begin
      res = '1;
    end else begin
      res = x[ByteW-1:0];
    end
    return res;
  endfunction

  assign luma_ext  = $signed({{(SumW-ByteW){1'b0}}, luma});
  assign red_sum   = luma_ext + {{(SumW-TermW){terms.red[TermW-1]}}, terms.red};
  assign green_sum = luma_ext - {{(SumW-TermW){terms.green[TermW-1]}}, terms.green};
  assign blue_sum  = luma_ext + {{(SumW-TermW){terms.blue[TermW-1]}}, terms.blue};

  always_comb begin
    pixel.red    = sat8(red_sum);
    pixel.green  = sat8(green_sum);
    pixel.blue   = sat8(blue_sum);
    pixel.rgb565 = {pixel.red[7:3], pixel.green[7:2], pixel.blue[7:3]};
  end

endmodule

// ----- hw/rtl/yrgb_merge.sv -----
`timescale 1ns / 1ps
module yrgb_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid,
  input  logic                  frame_last,
  input  yrgb_pkg::yrgb_pixel_t pixel_first,
  input  yrgb_pkg::yrgb_pixel_t pixel_second,
  output logic                  out_valid,
  output yrgb_pkg::yrgb_pixel_t out_first,
  output yrgb_pkg::yrgb_pixel_t out_second,
  output logic                  out_frame_end
);
  import yrgb_pkg::*;

  logic        valid_r;
  logic        frame_r;
  yrgb_pixel_t first_r;
  yrgb_pixel_t second_r;

  // Both lanes land in one output word together with the frame flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid;
    end
    frame_r  <= frame_last;
    first_r  <= pixel_first;
    second_r <= pixel_second;
  end

  assign out_valid     = valid_r;
  assign out_frame_end = frame_r;
  assign out_first     = first_r;
  assign out_second    = second_r;

endmodule

// ----- hw/rtl/yuyv_to_rgb_pixel_converter_top.sv -----
// YUYV 4:2:2 to RGB888 / RGB565 converter.
// Input: one macropixel word (two luma bytes, shared U and V bytes, and an
// end-of-frame flag) is taken at each rising edge where start is high and
// busy is low. busy is always low, so a word can be offered every cycle.
// Output: out_valid is high for exactly one cycle with both pixels as
// RGB888 bytes and as RGB565 words, plus the copied frame flag.
// From the accepting edge to out_valid the word passes one register
// after the shared chroma multipliers and one after the two
// pixel lanes and the merge. Throughput is one macropixel per cycle.
// The receiver cannot stall; every result is shown for one cycle only.
// Synchronous reset clears the valid pipeline, so no result appears until
// a word is accepted after reset. Words in flight at reset are dropped.
`timescale 1ns / 1ps
`include "yuyv_to_rgb_pixel_converter_top_assert.svh"
module yuyv_to_rgb_pixel_converter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [yrgb_pkg::ByteW-1:0]        in_luma_first,
  input  logic [yrgb_pkg::ByteW-1:0]        in_chroma_blue,
  input  logic [yrgb_pkg::ByteW-1:0]        in_luma_second,
  input  logic [yrgb_pkg::ByteW-1:0]        in_chroma_red,
  input  logic                              in_frame_last,
  output logic                              out_valid,
  output logic [yrgb_pkg::ByteW-1:0]        out_red_first,
  output logic [yrgb_pkg::ByteW-1:0]        out_green_first,
  output logic [yrgb_pkg::ByteW-1:0]        out_blue_first,
  output logic [yrgb_pkg::ByteW-1:0]        out_red_second,
  output logic [yrgb_pkg::ByteW-1:0]        out_green_second,
  output logic [yrgb_pkg::ByteW-1:0]        out_blue_second,
  output logic [yrgb_pkg::PackW-1:0]        out_packed_first,
  output logic [yrgb_pkg::PackW-1:0]        out_packed_second,
  output logic                              out_frame_end
);
  import yrgb_pkg::*;

  logic        accept;
  yrgb_stage_t stage;
  yrgb_pixel_t lane_first;
  yrgb_pixel_t lane_second;
  yrgb_pixel_t res_first;
  yrgb_pixel_t res_second;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  yrgb_chroma u_chroma (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .luma_first  (in_luma_first),
    .chroma_blue (in_chroma_blue),
    .luma_second (in_luma_second),
    .chroma_red  (in_chroma_red),
    .frame_last  (in_frame_last),
    .stage       (stage)
  );

  yrgb_lane u_lane_first (
    .luma  (stage.luma_first),
    .terms (stage.terms),
    .pixel (lane_first)
  );

  yrgb_lane u_lane_second (
    .luma  (stage.luma_second),
    .terms (stage.terms),
    .pixel (lane_second)
  );

  yrgb_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (stage.valid),
    .frame_last    (stage.frame_last),
    .pixel_first   (lane_first),
    .pixel_second  (lane_second),
    .out_valid     (out_valid),
    .out_first     (res_first),
    .out_second    (res_second),
    .out_frame_end (out_frame_end)
  );

  assign out_red_first     = res_first.red;
  assign out_green_first   = res_first.green;
  assign out_blue_first    = res_first.blue;
  assign out_packed_first  = res_first.rgb565;
  assign out_red_second    = res_second.red;
  assign out_green_second  = res_second.green;
  assign out_blue_second   = res_second.blue;
  assign out_packed_second = res_second.rgb565;

  // Every accepted word comes out on out_valid.
  `YRGB_ASSERT_SAME(a_latency, start && !busy, ##2 out_valid)
  // Every result traces back to an accepted word, flag included.
  `YRGB_ASSERT_SAME(a_origin, out_valid, $past(start, 2) && out_frame_end == $past(in_frame_last, 2))
  // Packed words agree with the saturated bytes of the same pixel.
  `YRGB_ASSERT_SAME(a_pack_first, out_valid, out_packed_first[15:11] == out_red_first[7:3] && out_packed_first[4:0] == out_blue_first[7:3])
  `YRGB_ASSERT_SAME(a_pack_second, out_valid, out_packed_second[10:5] == out_green_second[7:2] && out_packed_second[4:0] == out_blue_second[7:3])

endmodule
